[hw/rtl/output_restricted_deque_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the output-restricted deque.
// ---------------------------------------------------------------------------
`ifndef OUTPUT_RESTRICTED_DEQUE_DEFINES_SVH
`define OUTPUT_RESTRICTED_DEQUE_DEFINES_SVH

`ifndef ASSERT_OFF

// Check a property on every clock edge outside reset
`define ORD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included
`define ORD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define ORD_ASSERT(lbl, prop, msg)
`define ORD_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[hw/rtl/ord_pkg.sv]
// ---------------------------------------------------------------------------
// ord_pkg
// Shared types and constants of the output-restricted deque.
// ---------------------------------------------------------------------------
package ord_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int ENTRY_W        = 32;
    localparam int STATUS_W       = 2;

    // Request opcodes
    typedef enum logic [1:0] {
        MODE_PUSH_REAR  = 2'd0,
        MODE_PUSH_FRONT = 2'd1,
        MODE_POP        = 2'd2,
        MODE_NOP        = 2'd3
    } t_mode;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } t_status;

    // Per-cell operation, broadcast along the chain
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_TO_REAR    = 2'd1,
        CELL_TO_FRONT   = 2'd2,
        CELL_LOAD       = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     sel;
    } t_cell_ctrl;

endpackage

[hw/rtl/output_restricted_deque.sv]
// A result is presented in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; every operation
// moves the whole cell chain by at most one slot, and a stalled result holds
// off the next request until it is taken.
// The front of the deque always sits in cell 0, so a pop reads a fixed cell.
// Reset clears the entry count and the result valid; cell contents stay
// undefined and are never read before they are written.
// ---------------------------------------------------------------------------
// output_restricted_deque
// Deque with pushes at both ends and pops from the front, built as a
// shifting chain of cells with a registered result stage.
// ---------------------------------------------------------------------------
`include "output_restricted_deque_defines.svh"

module output_restricted_deque #(
    parameter int DEPTH      = ord_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ord_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_mode,
    input  logic [ord_pkg::ENTRY_W-1:0]  i_entry_value,
    // Result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [ord_pkg::ENTRY_W-1:0]  o_popped_value,
    output logic [ord_pkg::STATUS_W-1:0] o_status,
    output logic [CNT_W-1:0]             o_occupancy,
    output logic                         o_is_empty,
    output logic                         o_is_full
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic                        r_out_valid;
    logic [ord_pkg::ENTRY_W-1:0] r_popped_value;
    logic [ord_pkg::STATUS_W-1:0] r_status;
    logic [CNT_W-1:0]            r_occupancy;
    logic                        r_is_empty;
    logic                        r_is_full;

    logic [CNT_W-1:0]            r_count;
    logic [CNT_W-1:0]            n_count;

    logic                        w_accept;
    logic                        w_full;
    logic                        w_empty;
    ord_pkg::t_cell_op           w_op;
    ord_pkg::t_status            w_status;
    logic [ord_pkg::ENTRY_W-1:0] w_popped;
    logic [63:0]                 w_in_ext;
    logic [63:0]                 w_front_ext;
    logic [DATA_WIDTH-1:0]       w_word;
    logic [DATA_WIDTH-1:0]       w_cell_data [DEPTH];
    logic                        w_push_reject;
    logic                        w_empty_rsp;

    // Accept a request whenever the result stage is free or being drained
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_full  = (r_count == FULL_CNT);
    assign w_empty = (r_count == '0);

    // Fit the request word and the front word to the cell width
    assign w_in_ext    = {32'd0, i_entry_value};
    assign w_word      = w_in_ext[DATA_WIDTH-1:0];
    assign w_front_ext = 64'(w_cell_data[0]);

    // Decode the request into a chain operation, status and new count
    always_comb begin
        w_op     = ord_pkg::CELL_HOLD;
        w_status = ord_pkg::STATUS_DONE;
        w_popped = '0;
        n_count  = r_count;
        case (ord_pkg::t_mode'(i_mode))
            ord_pkg::MODE_PUSH_REAR: begin
                if (w_full) begin
                    w_status = ord_pkg::STATUS_FULL;
                end else begin
                    w_op    = ord_pkg::CELL_LOAD;
                    n_count = r_count + 1'b1;
                end
            end
            ord_pkg::MODE_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = ord_pkg::STATUS_FULL;
                end else begin
                    w_op    = ord_pkg::CELL_TO_REAR;
                    n_count = r_count + 1'b1;
                end
            end
            ord_pkg::MODE_POP: begin
                if (w_empty) begin
                    w_status = ord_pkg::STATUS_EMPTY;
                end else begin
                    w_op     = ord_pkg::CELL_TO_FRONT;
                    w_popped = w_front_ext[ord_pkg::ENTRY_W-1:0];
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
                w_op = ord_pkg::CELL_HOLD;
            end
        endcase
    end

    // Build the chain: cell 0 is the front, the new word enters there on a
    // front push; the first free cell takes it on a rear push
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        ord_pkg::t_cell_ctrl   w_ctrl;
        logic [DATA_WIDTH-1:0] w_front_nb;
        logic [DATA_WIDTH-1:0] w_rear_nb;

        assign w_ctrl.op  = w_accept ? w_op : ord_pkg::CELL_HOLD;
        assign w_ctrl.sel = (r_count == CNT_W'(g));

        if (g == 0) begin : g_head
            assign w_front_nb = w_word;
        end else begin : g_body
            assign w_front_nb = w_cell_data[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_rear_nb = w_cell_data[g];
        end else begin : g_inner
            assign w_rear_nb = w_cell_data[g+1];
        end

        ord_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_front_data (w_front_nb),
            .i_rear_data  (w_rear_nb),
            .i_word       (w_word),
            .o_data       (w_cell_data[g])
        );
    end

    // Advance the entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped_value <= w_popped;
            r_status       <= w_status;
            r_occupancy    <= n_count;
            r_is_empty     <= (n_count == '0);
            r_is_full      <= (n_count == FULL_CNT);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped_value;
    assign o_status       = r_status;
    assign o_occupancy    = r_occupancy;
    assign o_is_empty     = r_is_empty;
    assign o_is_full      = r_is_full;

    // Flag rejected pushes and empty-pop results for the checks
    assign w_push_reject = w_accept && (w_status == ord_pkg::STATUS_FULL);
    assign w_empty_rsp   = o_out_valid && (o_status == ord_pkg::STATUS_EMPTY);

    // Checks
    `ORD_ASSERT_ALWAYS(a_reset_clears_valid, !i_rst_n |=> !o_out_valid, "result valid after reset")
    `ORD_ASSERT(a_count_range, r_count <= FULL_CNT, "entry count beyond depth")
    `ORD_ASSERT(a_full_push_keeps_count, w_push_reject |=> $stable(r_count), "full push moved count")
    `ORD_ASSERT(a_accept_gives_result, w_accept |=> o_out_valid, "accepted request left no result")
    `ORD_ASSERT(a_empty_status_flag, w_empty_rsp |-> o_is_empty && o_popped_value == '0, "bad empty pop")

endmodule

[hw/rtl/ord_cell.sv]
// ---------------------------------------------------------------------------
// ord_cell
// One slot of the deque chain: takes its front or rear neighbor on a shift,
// or the new word when it is the first free slot on a rear push.
// ---------------------------------------------------------------------------
module ord_cell #(
    parameter int DATA_WIDTH = ord_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  ord_pkg::t_cell_ctrl   i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_front_data,
    input  logic [DATA_WIDTH-1:0] i_rear_data,
    input  logic [DATA_WIDTH-1:0] i_word,
    output logic [DATA_WIDTH-1:0] o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // Select the next slot content
    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            ord_pkg::CELL_HOLD:     n_data = r_data;
            ord_pkg::CELL_TO_REAR:  n_data = i_front_data;
            ord_pkg::CELL_TO_FRONT: n_data = i_rear_data;
            ord_pkg::CELL_LOAD:     n_data = i_ctrl.sel ? i_word : r_data;
            default:                n_data = r_data;
        endcase
    end

    // Hold the slot content
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[tb/sv/output_restricted_deque_tb.sv]
// ---------------------------------------------------------------------------
// output_restricted_deque_tb
// Drives push-rear, push-front, pop and no-op requests into the deque and
// checks every result against a shadow deque kept in the bench. The sender
// idles in random bursts, and the receiver stalls in changing patterns.
// ---------------------------------------------------------------------------
module output_restricted_deque_tb;

    import ord_pkg::*;

    localparam int DEPTH      = DEPTH_DEF;
    localparam int OCC_W      = $clog2(DEPTH + 1);
    localparam int RAND_OPS   = 1460;
    localparam int STUCK_MAX  = 2000;
    localparam int DRAIN_WAIT = 8;

    typedef struct {
        t_mode             mode;
        logic [ENTRY_W-1:0] value;
    } t_deque_req;

    typedef struct {
        logic [ENTRY_W-1:0]  popped;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
        logic                is_empty;
        logic                is_full;
    } t_deque_rsp;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_mode        = MODE_NOP;
    logic [ENTRY_W-1:0]  i_entry_value = '0;
    logic                o_out_valid;
    logic                i_out_stall   = 1'b0;
    logic [ENTRY_W-1:0]  o_popped_value;
    logic [STATUS_W-1:0] o_status;
    logic [OCC_W-1:0]    o_occupancy;
    logic                o_is_empty;
    logic                o_is_full;

    // Shadow deque state
    logic [ENTRY_W-1:0] shadow_store [DEPTH];
    int                 shadow_front = 0;
    int                 shadow_rear  = 0;
    int                 shadow_count = 0;

    t_deque_req requests_to_send [$];
    t_deque_rsp deque_outcomes   [$];
    int         drain_points     [$];

    int   mismatch_count = 0;
    int   sent_count     = 0;
    bit   req_taken      = 1'b0;
    int   gap_left       = 0;
    int   burst_left     = 0;
    int   stall_style    = 0;
    int   stall_left     = 0;
    int   stall_phase    = 0;
    int   stuck_cycles   = 0;

    output_restricted_deque u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_entry_value  (i_entry_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_popped_value (o_popped_value),
        .o_status       (o_status),
        .o_occupancy    (o_occupancy),
        .o_is_empty     (o_is_empty),
        .o_is_full      (o_is_full)
    );

    // Generate clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Apply one request to the shadow deque and queue its outcome
    task automatic shadow_apply(input t_mode mode, input logic [ENTRY_W-1:0] value);
        t_deque_rsp rsp;
        rsp.popped = '0;
        rsp.status = STATUS_DONE;
        case (mode)
            MODE_PUSH_REAR, MODE_PUSH_FRONT: begin
                if (shadow_count >= DEPTH) begin
                    rsp.status = STATUS_FULL;
                end else begin
                    if (shadow_count == 0) begin
                        // Empty store: both ends restart at slot 0
                        shadow_front = 0;
                        shadow_rear  = 0;
                        shadow_store[0] = value;
                    end else if (mode == MODE_PUSH_REAR) begin
                        shadow_rear = (shadow_rear + 1) % DEPTH;
                        shadow_store[shadow_rear] = value;
                    end else begin
                        shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
                        shadow_store[shadow_front] = value;
                    end
                    shadow_count++;
                end
            end
            MODE_POP: begin
                if (shadow_count == 0) begin
                    rsp.status = STATUS_EMPTY;
                end else begin
                    rsp.popped = shadow_store[shadow_front];
                    shadow_count--;
                    if (shadow_count == 0) begin
                        shadow_front = 0;
                        shadow_rear  = 0;
                    end else begin
                        shadow_front = (shadow_front + 1) % DEPTH;
                    end
                end
            end
            default: begin
            end
        endcase
        rsp.occupancy = OCC_W'(shadow_count);
        rsp.is_empty  = (shadow_count == 0);
        rsp.is_full   = (shadow_count == DEPTH);
        deque_outcomes.push_back(rsp);
    endtask

    // Report one field that differs from its expected value
    task automatic check_field(input string name, input logic [ENTRY_W-1:0] want,
                               input logic [ENTRY_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    task automatic add_request(input t_mode mode, input logic [ENTRY_W-1:0] value);
        t_deque_req req;
        req.mode  = mode;
        req.value = value;
        requests_to_send.push_back(req);
    endtask

    // Mix plain random words with corner patterns
    function automatic logic [ENTRY_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return ENTRY_W'(1) << $urandom_range(0, ENTRY_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // Sample the request and result channels
    always @(posedge i_clk) begin
        t_deque_rsp want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (deque_outcomes.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, actual status %h value %h",
                             $time, o_status, o_popped_value);
                end else begin
                    want = deque_outcomes.pop_front();
                    check_field("popped_value", want.popped, o_popped_value);
                    check_field("status", ENTRY_W'(want.status), ENTRY_W'(o_status));
                    check_field("occupancy", ENTRY_W'(want.occupancy), ENTRY_W'(o_occupancy));
                    check_field("is_empty", ENTRY_W'(want.is_empty), ENTRY_W'(o_is_empty));
                    check_field("is_full", ENTRY_W'(want.is_full), ENTRY_W'(o_is_full));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                shadow_apply(t_mode'(i_mode), i_entry_value);
                sent_count++;
                req_taken = 1'b1;
            end
        end
    end

    // Drive requests in bursts and the result stall on its own pattern
    always @(negedge i_clk) begin
        t_deque_req req;
        logic       next_valid;
        logic       next_stall;
        bit         hold_drain;
        next_valid = i_in_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else if (!i_in_valid || req_taken) begin
            next_valid = 1'b0;
            // Hold off at a drain point until every outcome has arrived
            hold_drain = 1'b0;
            if (drain_points.size() > 0 && sent_count == drain_points[0]) begin
                if (deque_outcomes.size() == 0) begin
                    void'(drain_points.pop_front());
                end else begin
                    hold_drain = 1'b1;
                end
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (!hold_drain && requests_to_send.size() > 0) begin
                req = requests_to_send.pop_front();
                i_mode        <= req.mode;
                i_entry_value <= req.value;
                next_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        req_taken = 1'b0;
        i_in_valid <= next_valid;

        // Advance the receiver stall pattern
        if (stall_left == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(20, 200);
            stall_phase = 0;
        end else begin
            stall_left--;
        end
        stall_phase++;
        case (stall_style)
            0:       next_stall = 1'b0;
            1:       next_stall = 1'($urandom_range(0, 1));
            2:       next_stall = ($urandom_range(0, 3) != 0);
            default: next_stall = ((stall_phase % 6) < 3);
        endcase
        i_out_stall <= next_stall;
    end

    // End the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_MAX) begin
            $display("output_restricted_deque verification failed");
            $finish;
        end
    end

    initial begin
        int target;
        int seg_len;
        int push_pct;
        int pick;

        // Directed: empty, last-entry and ignored-field cases
        add_request(MODE_POP, '0);
        add_request(MODE_NOP, '0);
        add_request(MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        add_request(MODE_PUSH_REAR, 32'h0000_0000);
        add_request(MODE_PUSH_FRONT, 32'hA5A5_A5A5);
        add_request(MODE_NOP, 32'h1234_5678);
        add_request(MODE_POP, '0);
        add_request(MODE_POP, '0);
        add_request(MODE_POP, '0);
        add_request(MODE_POP, '0);
        add_request(MODE_PUSH_REAR, 32'h5555_5555);
        add_request(MODE_POP, 32'hFFFF_FFFF);
        add_request(MODE_PUSH_REAR, 32'hAAAA_AAAA);
        add_request(MODE_PUSH_REAR, 32'h0000_0001);
        add_request(MODE_PUSH_FRONT, 32'h8000_0000);
        add_request(MODE_POP, 32'h5A5A_5A5A);
        add_request(MODE_POP, '0);
        add_request(MODE_POP, '0);
        add_request(MODE_NOP, 32'hFFFF_FFFF);
        add_request(MODE_POP, '0);
        drain_points.push_back(requests_to_send.size());

        // Fill past full, then drain past empty
        repeat (34) add_request($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR,
                                pick_word());
        repeat (34) add_request(MODE_POP, pick_word());

        target = requests_to_send.size() + RAND_OPS;
        drain_points.push_back(requests_to_send.size() + RAND_OPS / 2);
        while (requests_to_send.size() < target) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                repeat ($urandom_range(34, 40))
                    add_request($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR,
                                pick_word());
            end else if (pick == 1) begin
                repeat ($urandom_range(34, 40)) add_request(MODE_POP, pick_word());
            end else begin
                seg_len = $urandom_range(10, 60);
                case ($urandom_range(0, 2))
                    0:       push_pct = 15;
                    1:       push_pct = 50;
                    default: push_pct = 85;
                endcase
                repeat (seg_len) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 3)
                        add_request(MODE_NOP, pick_word());
                    else if (pick < 3 + push_pct)
                        add_request($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR,
                                    pick_word());
                    else
                        add_request(MODE_POP, pick_word());
                end
            end
        end

        // Hold reset, then release it
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for all requests and outcomes, then let the pipeline settle
        while (requests_to_send.size() != 0 || i_in_valid || deque_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("output_restricted_deque verification clean");
        else
            $display("output_restricted_deque verification failed");
        $finish;
    end

endmodule
